/* hdl/fdws_pkg.sv */
// ----------------------------------------------------------------------------
// fdws_pkg - shared types and constants for the doubleword write stager
// Action, kind and status codes, configuration defaults, the result record
// and page arithmetic helpers used by the stager modules.
// ----------------------------------------------------------------------------
package fdws_pkg;

    // Flash page geometry
    localparam int unsigned PAGE_SIZE = 2048;
    localparam int unsigned PAGE_LG   = $clog2(PAGE_SIZE);

    // Width of physical address arithmetic, wide enough for base plus range
    localparam int unsigned EW = 34;

    localparam int unsigned FP_W = 13;
    localparam int unsigned PC_W = 14;
    localparam logic [PC_W-1:0] PC_MAX = 14'd8192;

    localparam logic [EW-1:0] PAGE_MASK = EW'(PAGE_SIZE - 1);

    // Largest logical area the offset field can address
    localparam logic [24:0] AREA_CAP = 25'h100_0000;

    // Lane of the last byte in a doubleword
    localparam logic [2:0] LAST_LANE = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] CFG_STORAGE_BASE = 3'd0;
    localparam logic [2:0] CFG_AREA_SIZE    = 3'd1;
    localparam logic [2:0] CFG_BANK1_BASE   = 3'd2;
    localparam logic [2:0] CFG_BANK_SIZE    = 3'd3;
    localparam logic [2:0] CFG_TOTAL_SIZE   = 3'd4;
    localparam logic [2:0] CFG_DUAL_BANK    = 3'd5;

    // Configuration reset values
    localparam logic [31:0] RST_STORAGE_BASE = 32'd134250496;
    localparam logic [24:0] RST_AREA_SIZE    = 25'd65536;
    localparam logic [31:0] RST_BANK1_BASE   = 32'd134217728;
    localparam logic [24:0] RST_BANK_SIZE    = 25'd262144;
    localparam logic [25:0] RST_TOTAL_SIZE   = 26'd524288;
    localparam logic        RST_DUAL_BANK    = 1'b0;

    // Item actions
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_FLUSH = 2'd1,
        ACT_RESET = 2'd2,
        ACT_ERASE = 2'd3
    } t_action;

    // Result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_PROG   = 2'd1;
    localparam logic [1:0] KIND_ERASE  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_AREA  = 2'd1;
    localparam logic [1:0] ST_SEQ   = 2'd2;
    localparam logic [1:0] ST_ALIGN = 2'd3;

    typedef struct packed {
        t_action     action;
        logic [23:0] offset;
        logic [24:0] length;
        logic [7:0]  data_byte;
        logic        first;
    } t_item;

    typedef struct packed {
        logic [1:0]      kind;
        logic [1:0]      status;
        logic [31:0]     address;
        logic [63:0]     word;
        logic            bank;
        logic [FP_W-1:0] first_page;
        logic [PC_W-1:0] page_count;
    } t_res;

    // Configuration as seen by the datapath, with derived bounds
    typedef struct packed {
        logic [31:0]   storage_base;
        logic [24:0]   area;
        logic [31:0]   bank1_base;
        logic [EW-1:0] b1end;
        logic [EW-1:0] fend;
        logic          dual;
    } t_cfg;

    // Record between sequencing and erase split
    typedef struct packed {
        t_res          res;
        logic          erase;
        logic [EW-1:0] s;
        logic [EW-1:0] e;
    } t_mid;

    // Page index of a byte distance, low bits kept
    function automatic logic [FP_W-1:0] page_idx(input logic [EW-1:0] d);
        logic [EW-1:0] q;
        q = d >> PAGE_LG;
        return q[FP_W-1:0];
    endfunction

    // Page count of a byte distance, saturated
    function automatic logic [PC_W-1:0] page_cnt(input logic [EW-1:0] d);
        logic [EW-1:0] q;
        q = d >> PAGE_LG;
        if (q > EW'(PC_MAX)) begin
            return PC_MAX;
        end
        return q[PC_W-1:0];
    endfunction

endpackage

/* hdl/fdws_cfg.sv */
// ----------------------------------------------------------------------------
// fdws_cfg - configuration registers
// Holds the write-only registers and registers the derived area limit and
// bank bounds used by the datapath.
// ----------------------------------------------------------------------------
module fdws_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_wdata,
    output fdws_pkg::t_cfg    o_cfg
);
    import fdws_pkg::*;

    logic [31:0]   r_storage_base;
    logic [24:0]   r_area_size;
    logic [31:0]   r_bank1_base;
    logic [24:0]   r_bank_size;
    logic [25:0]   r_total_size;
    logic          r_dual;
    logic [24:0]   r_area;
    logic [EW-1:0] r_b1end;
    logic [EW-1:0] r_fend;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_storage_base <= RST_STORAGE_BASE;
            r_area_size    <= RST_AREA_SIZE;
            r_bank1_base   <= RST_BANK1_BASE;
            r_bank_size    <= RST_BANK_SIZE;
            r_total_size   <= RST_TOTAL_SIZE;
            r_dual         <= RST_DUAL_BANK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STORAGE_BASE: r_storage_base <= i_cfg_wdata;
                CFG_AREA_SIZE:    r_area_size    <= i_cfg_wdata[24:0];
                CFG_BANK1_BASE:   r_bank1_base   <= i_cfg_wdata;
                CFG_BANK_SIZE:    r_bank_size    <= i_cfg_wdata[24:0];
                CFG_TOTAL_SIZE:   r_total_size   <= i_cfg_wdata[25:0];
                CFG_DUAL_BANK:    r_dual         <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Derive clamped area and bank ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area  <= RST_AREA_SIZE;
            r_b1end <= EW'(RST_BANK1_BASE) + EW'(RST_BANK_SIZE);
            r_fend  <= EW'(RST_BANK1_BASE) + EW'(RST_TOTAL_SIZE);
        end else begin
            r_area  <= (r_area_size > AREA_CAP) ? AREA_CAP : r_area_size;
            r_b1end <= EW'(r_bank1_base) + EW'(r_bank_size);
            r_fend  <= EW'(r_bank1_base) + EW'(r_total_size);
        end
    end

    assign o_cfg.storage_base = r_storage_base;
    assign o_cfg.area         = r_area;
    assign o_cfg.bank1_base   = r_bank1_base;
    assign o_cfg.b1end        = r_b1end;
    assign o_cfg.fend         = r_fend;
    assign o_cfg.dual         = r_dual;

endmodule

/* hdl/fdws_seq.sv */
// ----------------------------------------------------------------------------
// fdws_seq - write sequencer
// Checks write calls, packs bytes into the staged doubleword, handles flush
// and sequence reset, and prepares the aligned range of an erase.
// ----------------------------------------------------------------------------
module fdws_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  fdws_pkg::t_item   i_item,
    input  fdws_pkg::t_cfg    i_cfg,
    output fdws_pkg::t_mid    o_mid
);
    import fdws_pkg::*;

    logic [24:0]   r_next_off, n_next_off;
    logic [23:0]   r_stage_off, n_stage_off;
    logic [63:0]   r_word, n_word;
    logic [2:0]    r_count, n_count;
    logic [1:0]    r_reject, n_reject;

    logic          span_bad;
    logic          seq_bad;
    logic          unaligned;
    logic [63:0]   ins_word;
    logic [23:0]   stage_off;
    logic          take;
    logic [1:0]    code;
    logic [EW-1:0] phys_a;
    logic [EW-1:0] phys_e;

    // Checks on the call start
    assign span_bad  = (26'(i_item.offset) + 26'(i_item.length)) > 26'(i_cfg.area);
    assign seq_bad   = 25'(i_item.offset) != r_next_off;
    assign unaligned = (r_count == 3'd0) && (i_item.offset[2:0] != 3'd0);

    // Erase range in physical bytes, page aligned
    assign phys_a = EW'(i_cfg.storage_base) + EW'(i_item.offset);
    assign phys_e = phys_a + EW'(i_item.length) + PAGE_MASK;

    // Insert the byte into its lane
    always_comb begin
        ins_word = r_word;
        ins_word[{r_count, 3'b000} +: 8] = i_item.data_byte;
    end

    // Next state and result
    always_comb begin
        n_next_off  = r_next_off;
        n_stage_off = r_stage_off;
        n_word      = r_word;
        n_count     = r_count;
        n_reject    = r_reject;
        take        = 1'b0;
        code        = ST_OK;
        stage_off   = (r_count == 3'd0) ? r_next_off[23:0] : r_stage_off;
        o_mid       = '0;
        o_mid.s     = phys_a & ~PAGE_MASK;
        o_mid.e     = phys_e & ~PAGE_MASK;
        unique case (i_item.action)
            ACT_WRITE: begin
                if (i_item.first) begin
                    if (span_bad) begin
                        code = ST_AREA;
                    end else if (seq_bad) begin
                        code = ST_SEQ;
                    end else if (unaligned) begin
                        code = ST_ALIGN;
                    end
                    n_reject = code;
                    o_mid.res.status = code;
                    take = (code == ST_OK);
                end else if (r_reject != ST_OK) begin
                    o_mid.res.status = r_reject;
                end else if (r_next_off >= i_cfg.area) begin
                    n_reject = ST_AREA;
                    o_mid.res.status = ST_AREA;
                end else begin
                    take = 1'b1;
                end
                // Stage the byte; emit the word when the last lane fills
                if (take) begin
                    n_stage_off = stage_off;
                    n_word      = ins_word;
                    n_count     = r_count + 3'd1;
                    n_next_off  = r_next_off + 25'd1;
                    if (r_count == LAST_LANE) begin
                        o_mid.res.kind    = KIND_PROG;
                        o_mid.res.address = i_cfg.storage_base + 32'(stage_off);
                        o_mid.res.word    = ins_word;
                        n_word            = '1;
                        n_count           = 3'd0;
                        n_stage_off       = n_next_off[23:0];
                    end
                end
            end
            ACT_FLUSH: begin
                if (r_count != 3'd0) begin
                    o_mid.res.kind    = KIND_PROG;
                    o_mid.res.address = i_cfg.storage_base + 32'(r_stage_off);
                    o_mid.res.word    = r_word;
                    n_word            = '1;
                    n_count           = 3'd0;
                end
            end
            ACT_RESET: begin
                n_next_off  = 25'(i_item.offset);
                n_stage_off = i_item.offset;
                n_word      = '1;
                n_count     = 3'd0;
            end
            ACT_ERASE: begin
                if (span_bad) begin
                    o_mid.res.status = ST_AREA;
                end else begin
                    n_next_off  = 25'(i_item.offset);
                    n_stage_off = i_item.offset;
                    n_word      = '1;
                    n_count     = 3'd0;
                    o_mid.erase = (i_item.length != 25'd0);
                end
            end
            default: begin
            end
        endcase
    end

    // Advance state on each processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_off  <= '0;
            r_stage_off <= '0;
            r_word      <= '1;
            r_count     <= '0;
            r_reject    <= ST_OK;
        end else if (i_go) begin
            r_next_off  <= n_next_off;
            r_stage_off <= n_stage_off;
            r_word      <= n_word;
            r_count     <= n_count;
            r_reject    <= n_reject;
        end
    end

endmodule

/* hdl/fdws_split.sv */
// ----------------------------------------------------------------------------
// fdws_split - erase range splitter
// Clips an aligned erase range to flash and splits it at the bank boundary
// into up to two page-erase results.
// ----------------------------------------------------------------------------
module fdws_split (
    input  fdws_pkg::t_mid    i_mid,
    input  fdws_pkg::t_cfg    i_cfg,
    output fdws_pkg::t_res    o_slot0,
    output fdws_pkg::t_res    o_slot1,
    output logic              o_two
);
    import fdws_pkg::*;

    logic [EW-1:0] b1;
    logic [EW-1:0] sc;
    logic [EW-1:0] lim_hi;
    logic [EW-1:0] lim_lo;
    logic          hi_only;
    logic          vx;
    logic          vy;
    t_res          seg_x;
    t_res          seg_y;

    assign b1      = EW'(i_cfg.bank1_base);
    assign sc      = (i_mid.s < b1) ? b1 : i_mid.s;
    assign hi_only = i_cfg.dual && (i_mid.s >= i_cfg.b1end);
    assign lim_hi  = (i_mid.e < i_cfg.fend)  ? i_mid.e : i_cfg.fend;
    assign lim_lo  = (i_mid.e < i_cfg.b1end) ? i_mid.e : i_cfg.b1end;

    // First segment: bank two only, or the bank one part
    always_comb begin
        seg_x      = '0;
        seg_x.kind = KIND_ERASE;
        if (hi_only) begin
            vx               = lim_hi > sc;
            seg_x.bank       = 1'b1;
            seg_x.first_page = page_idx(sc - i_cfg.b1end);
            seg_x.page_count = page_cnt(lim_hi - sc);
        end else begin
            vx               = lim_lo > sc;
            seg_x.first_page = page_idx(sc - b1);
            seg_x.page_count = page_cnt(lim_lo - sc);
        end
    end

    // Second segment: spill into bank two
    always_comb begin
        seg_y            = '0;
        seg_y.kind       = KIND_ERASE;
        seg_y.bank       = 1'b1;
        seg_y.page_count = page_cnt(lim_hi - i_cfg.b1end);
        vy = !hi_only && i_cfg.dual && (i_mid.e > i_cfg.b1end) && (lim_hi > i_cfg.b1end);
    end

    // Order results; an empty erase reports ok
    always_comb begin
        o_slot1 = seg_y;
        o_two   = 1'b0;
        if (!i_mid.erase) begin
            o_slot0 = i_mid.res;
        end else if (vx) begin
            o_slot0 = seg_x;
            o_two   = vy;
        end else if (vy) begin
            o_slot0 = seg_y;
        end else begin
            o_slot0 = '0;
        end
    end

endmodule

/* hdl/fdws_outbuf.sv */
// ----------------------------------------------------------------------------
// fdws_outbuf - result register
// Holds the one or two results of an item and presents them in order,
// marking the final one.
// ----------------------------------------------------------------------------
module fdws_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  fdws_pkg::t_res    i_slot0,
    input  fdws_pkg::t_res    i_slot1,
    input  logic              i_two,
    input  logic              i_out_ready,
    output logic              o_free,
    output logic              o_valid,
    output logic              o_last,
    output fdws_pkg::t_res    o_res
);
    import fdws_pkg::*;

    logic r_valid;
    logic r_two;
    logic r_sel;
    t_res r_slot0;
    t_res r_slot1;
    logic out_acc;

    assign o_valid = r_valid;
    assign o_last  = !r_two || r_sel;
    assign o_res   = r_sel ? r_slot1 : r_slot0;
    assign out_acc = r_valid && i_out_ready;
    assign o_free  = !r_valid || (i_out_ready && o_last);

    // Control: load a new item or step to its second result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_two   <= 1'b0;
            r_sel   <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_two   <= i_two;
            r_sel   <= 1'b0;
        end else if (out_acc) begin
            if (o_last) begin
                r_valid <= 1'b0;
            end else begin
                r_sel <= 1'b1;
            end
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot0 <= i_slot0;
            r_slot1 <= i_slot1;
        end
    end

endmodule

/* hdl/flash_doubleword_write_stager.sv */
// ----------------------------------------------------------------------------
// flash_doubleword_write_stager - doubleword write stager for a flash programmer
// Packs write bytes into 64-bit program commands and splits erase ranges into
// per-bank page-erase commands.
//
//   channel   direction  handshake                   contents
//   in        to block   i_in_valid / o_in_ready     action, offset, length, byte
//   out       from block o_out_valid / i_out_ready   one or two results per word
//   cfg       to block   i_cfg_we                    register index and data
//
// An accepted word passes the input register, the sequencing stage into the middle
// register, and the result register before its first result appears.
// One word is taken per cycle while the output does not stall; an erase that yields
// two results holds the result register until both have been taken.
// A stall on the output backs up through the result, middle and input
// registers; each stage moves when the one after it frees.
// Reset is synchronous; it restores the default configuration and clears
// the staged doubleword and sequence.
// ----------------------------------------------------------------------------
module flash_doubleword_write_stager (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [1:0]   i_action,
    input  logic [23:0]  i_offset,
    input  logic [24:0]  i_length,
    input  logic [7:0]   i_data_byte,
    input  logic         i_first,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [1:0]   o_kind,
    output logic [1:0]   o_status,
    output logic [31:0]  o_address,
    output logic [63:0]  o_word,
    output logic         o_bank,
    output logic [12:0]  o_first_page,
    output logic [13:0]  o_page_count,
    output logic         o_last
);
    import fdws_pkg::*;

    t_cfg  cfg;
    logic  r_in_v;
    t_item r_item;
    logic  r_mid_v;
    t_mid  r_mid;
    t_mid  mid_n;
    logic  mid_ready;
    logic  in_go;
    logic  res_free;
    logic  mid_go;
    t_res  slot0;
    t_res  slot1;
    logic  two;
    t_res  res;

    assign mid_ready  = !r_mid_v || res_free;
    assign o_in_ready = !r_in_v || mid_ready;
    assign in_go      = r_in_v && mid_ready;
    assign mid_go     = r_mid_v && res_free;

    fdws_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_in_ready) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.action    <= t_action'(i_action);
            r_item.offset    <= i_offset;
            r_item.length    <= i_length;
            r_item.data_byte <= i_data_byte;
            r_item.first     <= i_first;
        end
    end

    fdws_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (in_go),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_mid   (mid_n)
    );

    // Middle register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_v <= 1'b0;
        end else if (mid_ready) begin
            r_mid_v <= r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_mid <= mid_n;
        end
    end

    fdws_split u_split (
        .i_mid   (r_mid),
        .i_cfg   (cfg),
        .o_slot0 (slot0),
        .o_slot1 (slot1),
        .o_two   (two)
    );

    fdws_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (mid_go),
        .i_slot0     (slot0),
        .i_slot1     (slot1),
        .i_two       (two),
        .i_out_ready (i_out_ready),
        .o_free      (res_free),
        .o_valid     (o_out_valid),
        .o_last      (o_last),
        .o_res       (res)
    );

    assign o_kind       = res.kind;
    assign o_status     = res.status;
    assign o_address    = res.address;
    assign o_word       = res.word;
    assign o_bank       = res.bank;
    assign o_first_page = res.first_page;
    assign o_page_count = res.page_count;

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench - self-checking bench for flash_doubleword_write_stager
// Drives write bytes, flushes, sequence resets and erase ranges through the
// valid/ready input channel under several register settings and idle
// patterns. A scoreboard class predicts every program, erase and status
// command and compares each accepted output word field by field.
// ----------------------------------------------------------------------------
module testbench;

    import fdws_pkg::*;

    // Cycles to let pass once nothing is pending
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [31:0] address;
        logic [63:0] word;
        logic        bank;
        logic [12:0] first_page;
        logic [13:0] page_count;
        logic        last;
    } t_flash_cmd;

    // ------------------------------------------------------------------------
    // Command scoreboard: shadow registers, staging state and due commands
    // ------------------------------------------------------------------------
    class t_cmd_board;
        logic [31:0] storage_base;
        logic [24:0] area_size;
        logic [31:0] bank1_base;
        logic [24:0] bank_size;
        logic [25:0] total_size;
        logic        dual_bank;

        logic [24:0] next_off;
        logic [23:0] staged_off;
        logic [63:0] staged_word;
        logic [2:0]  staged_cnt;
        logic [1:0]  reject_code;

        t_flash_cmd  due_cmds[$];
        int          errors;

        function new();
            storage_base = RST_STORAGE_BASE;
            area_size    = RST_AREA_SIZE;
            bank1_base   = RST_BANK1_BASE;
            bank_size    = RST_BANK_SIZE;
            total_size   = RST_TOTAL_SIZE;
            dual_bank    = RST_DUAL_BANK;
            restart(24'd0);
            reject_code  = ST_OK;
            errors       = 0;
        endfunction

        function void restart(logic [23:0] at);
            next_off    = 25'(at);
            staged_off  = at;
            staged_word = '1;
            staged_cnt  = '0;
        endfunction

        function longint unsigned area_eff();
            return (area_size > AREA_CAP) ? AREA_CAP : area_size;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                CFG_STORAGE_BASE: storage_base = val;
                CFG_AREA_SIZE:    area_size    = val[24:0];
                CFG_BANK1_BASE:   bank1_base   = val;
                CFG_BANK_SIZE:    bank_size    = val[24:0];
                CFG_TOTAL_SIZE:   total_size   = val[25:0];
                CFG_DUAL_BANK:    dual_bank    = val[0];
                default: ;
            endcase
        endfunction

        // Queue one command; page index keeps its low bits, count saturates
        function void emit(logic [1:0] kind, logic [1:0] status, longint unsigned addr,
                           logic [63:0] word, logic bank, longint unsigned fp,
                           longint unsigned pc);
            t_flash_cmd c;
            c.kind       = kind;
            c.status     = status;
            c.address    = addr[31:0];
            c.word       = word;
            c.bank       = bank;
            c.first_page = fp[12:0];
            c.page_count = (pc > PC_MAX) ? PC_MAX : pc[13:0];
            c.last       = 1'b0;
            due_cmds.push_back(c);
        endfunction

        // Check, stage and pack one write byte
        function void stage_byte(t_item it);
            longint unsigned area, off, len;
            logic [1:0] code;
            logic [2:0] lane;
            area = area_eff();
            off  = it.offset;
            len  = it.length;
            if (it.first) begin
                code = ST_OK;
                if (off > area || len > area - off) code = ST_AREA;
                else if (off != next_off) code = ST_SEQ;
                else if (staged_cnt == 0 && off[2:0] != 0) code = ST_ALIGN;
                reject_code = code;
                if (code != ST_OK) begin
                    emit(KIND_STATUS, code, 0, '0, 1'b0, 0, 0);
                    return;
                end
            end else if (reject_code != ST_OK) begin
                emit(KIND_STATUS, reject_code, 0, '0, 1'b0, 0, 0);
                return;
            end else if (next_off >= area) begin
                reject_code = ST_AREA;
                emit(KIND_STATUS, ST_AREA, 0, '0, 1'b0, 0, 0);
                return;
            end
            if (staged_cnt == 0) staged_off = next_off[23:0];
            lane = staged_cnt;
            staged_word[8*lane +: 8] = it.data_byte;
            next_off = next_off + 1'b1;
            if (lane == LAST_LANE) begin
                emit(KIND_PROG, ST_OK, longint'(storage_base) + staged_off, staged_word,
                     1'b0, 0, 0);
                staged_word = '1;
                staged_cnt  = '0;
                staged_off  = next_off[23:0];
            end else begin
                staged_cnt = lane + 1'b1;
                emit(KIND_STATUS, ST_OK, 0, '0, 1'b0, 0, 0);
            end
        endfunction

        // Page-align the range and split it at the bank boundary
        function void split_erase(t_item it);
            longint unsigned area, off, len, a, s, e, b1, b1end, fend, lim;
            int n;
            area = area_eff();
            off  = it.offset;
            len  = it.length;
            n    = 0;
            if (off > area || len > area - off) begin
                emit(KIND_STATUS, ST_AREA, 0, '0, 1'b0, 0, 0);
                return;
            end
            restart(it.offset);
            if (len != 0) begin
                a     = longint'(storage_base) + off;
                s     = a - a % PAGE_SIZE;
                e     = ((a + len + PAGE_SIZE - 1) / PAGE_SIZE) * PAGE_SIZE;
                b1    = bank1_base;
                b1end = b1 + bank_size;
                fend  = b1 + total_size;
                if (s < b1) s = b1;
                if (dual_bank && s >= b1end) begin
                    lim = (e < fend) ? e : fend;
                    if (lim > s) begin
                        emit(KIND_ERASE, ST_OK, 0, '0, 1'b1, (s - b1end) / PAGE_SIZE,
                             (lim - s) / PAGE_SIZE);
                        n++;
                    end
                end else begin
                    lim = (e < b1end) ? e : b1end;
                    if (lim > s) begin
                        emit(KIND_ERASE, ST_OK, 0, '0, 1'b0, (s - b1) / PAGE_SIZE,
                             (lim - s) / PAGE_SIZE);
                        n++;
                    end
                    if (dual_bank && e > b1end) begin
                        lim = (e < fend) ? e : fend;
                        if (lim > b1end) begin
                            emit(KIND_ERASE, ST_OK, 0, '0, 1'b1, 0,
                                 (lim - b1end) / PAGE_SIZE);
                            n++;
                        end
                    end
                end
            end
            if (n == 0) emit(KIND_STATUS, ST_OK, 0, '0, 1'b0, 0, 0);
        endfunction

        // Predict the commands caused by one accepted input word
        function void note_word(t_item it);
            case (it.action)
                ACT_WRITE: stage_byte(it);
                ACT_FLUSH: begin
                    if (staged_cnt != 0) begin
                        emit(KIND_PROG, ST_OK, longint'(storage_base) + staged_off,
                             staged_word, 1'b0, 0, 0);
                        staged_word = '1;
                        staged_cnt  = '0;
                    end else begin
                        emit(KIND_STATUS, ST_OK, 0, '0, 1'b0, 0, 0);
                    end
                end
                ACT_RESET: begin
                    restart(it.offset);
                    emit(KIND_STATUS, ST_OK, 0, '0, 1'b0, 0, 0);
                end
                default: split_erase(it);
            endcase
            due_cmds[due_cmds.size() - 1].last = 1'b1;
        endfunction

        // Compare one output word with the oldest due command
        function void check_cmd(t_flash_cmd got);
            t_flash_cmd want;
            if (due_cmds.size() == 0) begin
                errors++;
                $error("unexpected command: kind %0d status %0d", got.kind, got.status);
                return;
            end
            want = due_cmds.pop_front();
            if (got.kind !== want.kind) begin
                errors++;
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
            end
            if (got.status !== want.status) begin
                errors++;
                $error("status: expected %0d, got %0d", want.status, got.status);
            end
            if (got.address !== want.address) begin
                errors++;
                $error("address: expected %h, got %h", want.address, got.address);
            end
            if (got.word !== want.word) begin
                errors++;
                $error("word: expected %h, got %h", want.word, got.word);
            end
            if (got.bank !== want.bank) begin
                errors++;
                $error("bank: expected %0d, got %0d", want.bank, got.bank);
            end
            if (got.first_page !== want.first_page) begin
                errors++;
                $error("first_page: expected %0d, got %0d", want.first_page,
                       got.first_page);
            end
            if (got.page_count !== want.page_count) begin
                errors++;
                $error("page_count: expected %0d, got %0d", want.page_count,
                       got.page_count);
            end
            if (got.last !== want.last) begin
                errors++;
                $error("last: expected %0d, got %0d", want.last, got.last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_action;
    logic [23:0] i_offset;
    logic [24:0] i_length;
    logic [7:0]  i_data_byte;
    logic        i_first;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_kind;
    logic [1:0]  o_status;
    logic [31:0] o_address;
    logic [63:0] o_word;
    logic        o_bank;
    logic [12:0] o_first_page;
    logic [13:0] o_page_count;
    logic        o_last;

    t_cmd_board     board;
    t_flash_cmd     seen_cmd;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             items_sent;
    int             phase_no;

    flash_doubleword_write_stager DUT (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Output side: check accepted words, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_cmd.kind       = o_kind;
            seen_cmd.status     = o_status;
            seen_cmd.address    = o_address;
            seen_cmd.word       = o_word;
            seen_cmd.bank       = o_bank;
            seen_cmd.first_page = o_first_page;
            seen_cmd.page_count = o_page_count;
            seen_cmd.last       = o_last;
            board.check_cmd(seen_cmd);
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic set_idle(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
    endtask

    // Present one word, hold it until accepted, then maybe idle
    task automatic send_item(t_action act, logic [23:0] off, logic [24:0] len,
                             logic [7:0] data, logic first);
        t_item it;
        it.action    = act;
        it.offset    = off;
        it.length    = len;
        it.data_byte = data;
        it.first     = first;
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_offset    <= off;
        i_length    <= len;
        i_data_byte <= data;
        i_first     <= first;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_word(it);
        items_sent++;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every due command has come out
    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.due_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        board.set_reg(idx, val);
    endtask

    task automatic program_regs(logic [31:0] sbase, logic [31:0] area, logic [31:0] fbase,
                                logic [31:0] bank, logic [31:0] fsize, logic [31:0] dual);
        settle();
        write_reg(CFG_STORAGE_BASE, sbase);
        write_reg(CFG_AREA_SIZE, area);
        write_reg(CFG_BANK1_BASE, fbase);
        write_reg(CFG_BANK_SIZE, bank);
        write_reg(CFG_TOTAL_SIZE, fsize);
        write_reg(CFG_DUAL_BANK, dual);
        i_cfg_we <= 1'b0;
    endtask

    // Aligned restart point, often near the area end
    function automatic logic [23:0] pick_start(int unsigned ae);
        int unsigned off;
        if (ae == 0) return 24'd0;
        if (ae > 64 && $urandom_range(3) == 0) off = ae - $urandom_range(1, 64);
        else off = $urandom_range(0, ae - 1);
        return 24'(off) & 24'hFF_FFF8;
    endfunction

    // One random step: mostly sequential write calls, some control and noise
    task automatic random_step();
        int unsigned ae, pick, n_bytes, avail, off, top;
        logic [24:0] call_len;
        ae   = 32'(board.area_eff());
        pick = $urandom_range(99);
        if (board.staged_cnt == 0 && board.next_off[2:0] != 0 && $urandom_range(9) < 7) begin
            send_item(ACT_RESET, pick_start(ae), 25'($urandom), 8'($urandom), 1'($urandom));
        end else if (pick < 70) begin
            n_bytes  = $urandom_range(1, 20);
            avail    = (ae > board.next_off) ? ae - board.next_off : 0;
            call_len = ($urandom_range(9) == 0) ? 25'($urandom_range(0, 40))
                                                : 25'((n_bytes < avail) ? n_bytes : avail);
            off      = board.next_off;
            for (int i = 0; i < n_bytes; i++) begin
                if (i != 0 && $urandom_range(19) == 0) begin
                    send_item(ACT_FLUSH, 24'($urandom), 25'($urandom), 8'($urandom),
                              1'($urandom));
                end
                send_item(ACT_WRITE, 24'(off), call_len, 8'($urandom), i == 0);
            end
        end else if (pick < 78) begin
            send_item(ACT_FLUSH, 24'($urandom), 25'($urandom), 8'($urandom), 1'($urandom));
        end else if (pick < 85) begin
            if ($urandom_range(4) == 0) off = $urandom;
            else off = pick_start(ae);
            send_item(ACT_RESET, 24'(off), 25'($urandom), 8'($urandom), 1'($urandom));
        end else if (pick < 93) begin
            top = (ae > 32'hFF_FFFF) ? 32'hFF_FFFF : ae;
            off = $urandom_range(0, top);
            case ($urandom_range(2))
                0: call_len = 25'($urandom_range(0, 3 * PAGE_SIZE));
                1: call_len = 25'($urandom_range(0, ae - off));
                default: call_len = 25'($urandom_range(0, 32'h100_0000));
            endcase
            send_item(ACT_ERASE, 24'(off), call_len, 8'($urandom), 1'($urandom));
        end else begin
            send_item(t_action'($urandom_range(3)), 24'($urandom),
                      25'($urandom_range(0, 32'h100_0000)), 8'($urandom), 1'($urandom));
        end
        // hold off now and then until the pipeline is empty
        if ($urandom_range(199) == 0) settle();
    endtask

    // Erase the whole area and its upper half, restart, then random traffic
    task automatic run_phase(int count);
        int unsigned ae;
        int start;
        phase_no++;
        ae = 32'(board.area_eff());
        start = items_sent;
        send_item(ACT_ERASE, 24'd0, 25'(ae), 8'h00, 1'b0);
        send_item(ACT_ERASE, 24'(ae / 2), 25'(ae - ae / 2), 8'hFF, 1'b1);
        send_item(ACT_RESET, 24'd0, 25'd0, 8'h00, 1'b0);
        while (items_sent - start < count) begin
            set_idle((items_sent / 40 + phase_no) % 4);
            random_step();
        end
    endtask

    initial begin
        logic [31:0] r_fbase, r_bank, r_fsize, r_area;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_action    <= ACT_WRITE;
        i_offset    <= '0;
        i_length    <= '0;
        i_data_byte <= '0;
        i_first     <= 1'b0;
        i_out_ready <= 1'b0;
        items_sent  = 0;
        phase_no    = 0;
        board       = new();
        set_idle(0);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed checks with the reset settings
        send_item(ACT_FLUSH, 24'd0, 25'd0, 8'h00, 1'b0);           // nothing staged
        send_item(ACT_WRITE, 24'd0, 25'd0, 8'h00, 1'b1);           // zero-length call
        send_item(ACT_WRITE, 24'd0, 25'd0, 8'hFF, 1'b0);
        send_item(ACT_FLUSH, 24'd0, 25'd0, 8'h00, 1'b0);           // partial word
        send_item(ACT_WRITE, 24'd7, 25'd1, 8'h11, 1'b1);           // out of sequence
        send_item(ACT_WRITE, 24'd8, 25'd1, 8'h22, 1'b0);           // repeats rejection
        send_item(ACT_RESET, 24'd3, 25'd0, 8'h00, 1'b0);
        send_item(ACT_WRITE, 24'd3, 25'd4, 8'h33, 1'b1);           // unaligned start
        send_item(ACT_WRITE, 24'hFF_FFFF, 25'h100_0000, 8'h5A, 1'b1); // out of area
        send_item(ACT_RESET, 24'h00_FFF8, 25'd0, 8'h00, 1'b0);
        for (int i = 0; i < 8; i++) begin
            send_item(ACT_WRITE, 24'h00_FFF8, 25'd8, 8'(8'hA5 + 8'h11 * i), i == 0);
        end
        send_item(ACT_WRITE, 24'h00_FFF8, 25'd8, 8'h77, 1'b0);     // past the area end
        send_item(ACT_ERASE, 24'h00_FFFF, 25'd2, 8'h00, 1'b0);     // erase out of area
        send_item(ACT_ERASE, 24'd0, 25'd0, 8'h00, 1'b0);           // empty erase
        send_item(ACT_ERASE, 24'h00_0800, 25'h000_3000, 8'h00, 1'b0);
        send_item(ACT_ERASE, 24'd0, 25'h001_0000, 8'h00, 1'b0);
        send_item(ACT_FLUSH, 24'd0, 25'd0, 8'h00, 1'b0);
        run_phase(120);

        // Area that straddles the bank boundary, bank two clipped
        program_regs(32'h0800_F000, 32'h0000_4000, 32'h0800_0000, 32'h0001_0000,
                     32'h0001_2000, 32'd1);
        run_phase(130);

        // Largest values, area above the offset range, address wrap
        program_regs(32'hFFFF_FFFF, 32'h01FF_FFFF, 32'hFFFF_FFFF, 32'h0100_0000,
                     32'h0200_0000, 32'd1);
        run_phase(110);

        // Empty bank one, long bank two range: page count saturates
        program_regs(32'h0800_0001, 32'h0100_0000, 32'h0800_0000, 32'h0000_0000,
                     32'h0200_0000, 32'd1);
        run_phase(110);

        // Everything zero
        program_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        run_phase(50);

        // Random layouts with the area close to the banks
        for (int k = 0; k < 3; k++) begin
            r_fbase = $urandom & 32'hFFFF_F800;
            r_bank  = $urandom_range(1, 64) * PAGE_SIZE;
            r_fsize = r_bank * $urandom_range(1, 2) + $urandom_range(0, 3) * PAGE_SIZE;
            r_area  = $urandom_range(8, 32'h8000);
            program_regs(r_fbase + $urandom_range(0, 2 * r_bank), r_area, r_fbase,
                         r_bank, r_fsize, $urandom_range(1));
            run_phase(120);
        end

        settle();
        if (board.errors == 0 && board.due_cmds.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
